// ----- hdl/lsp_pkg.sv -----
// shared types, widths and constants for the line sensor position unit
package lsp_pkg;

	localparam int NUM_SENSORS = 8;

	localparam int SAMPLE_W = 16;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int DELTA_W  = DIFF_W + 1;
	localparam int PITCH_W  = 8;
	localparam int GAIN_W   = 16;
	localparam int POS_W    = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int CH_W   = $clog2(NUM_SENSORS);
	localparam int STEP_W = $clog2(2 * NUM_SENSORS);

	// offset before pitch scaling, in 1/(4096*256) sensor pitches
	localparam int V_W      = GAIN_W + DELTA_W + 1;
	localparam int PROD_W   = V_W + PITCH_W + 1;
	localparam int Q_W      = PROD_W - 8;
	localparam int CENTER_SHIFT = 20;
	localparam int ROUND_BIAS   = 128;

	localparam logic signed [V_W-1:0] CENTER_BASE = V_W'((NUM_SENSORS - 1) * 2048 * 256);
	localparam logic [STEP_W-1:0] STEP_HALF = STEP_W'(NUM_SENSORS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * NUM_SENSORS - 1);
	localparam logic [CH_W-1:0]   SCAN_FIRST = CH_W'(1);
	localparam logic [CH_W-1:0]   SCAN_LAST  = CH_W'(NUM_SENSORS - 2);

	localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(9);
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(84);

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PITCH = 1'b0,
		REG_GAIN  = 1'b1
	} cfg_reg_t;

	typedef logic [CH_W-1:0] ch_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef struct packed {
		logic wr;
		logic sub;
		ch_t  addr;
	} store_ctl_t;

endpackage

// ----- hdl/lsp_diff_store.sv -----
// per-channel difference registers for the front and back rows
module lsp_diff_store (
	input  logic                           clk,
	input  lsp_pkg::store_ctl_t            ctl,
	input  logic [lsp_pkg::SAMPLE_W-1:0]   front_sample,
	input  logic [lsp_pkg::SAMPLE_W-1:0]   back_sample,
	output lsp_pkg::diff_t                 rd_front,
	output lsp_pkg::diff_t                 rd_back
);

	lsp_pkg::diff_t front_mem_q [lsp_pkg::NUM_SENSORS];
	lsp_pkg::diff_t back_mem_q  [lsp_pkg::NUM_SENSORS];

	assign rd_front = front_mem_q[ctl.addr];
	assign rd_back  = back_mem_q[ctl.addr];

	// first half of a frame loads the off reading, second half subtracts the on reading
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			if (ctl.sub) begin
				front_mem_q[ctl.addr] <= rd_front - {1'b0, front_sample};
				back_mem_q[ctl.addr]  <= rd_back - {1'b0, back_sample};
			end else begin
				front_mem_q[ctl.addr] <= {1'b0, front_sample};
				back_mem_q[ctl.addr]  <= {1'b0, back_sample};
			end
		end
	end

endmodule

// ----- hdl/lsp_mul.sv -----
// shared signed multiplier with registered product
module lsp_mul (
	input  logic                                clk,
	input  logic signed [lsp_pkg::V_W-1:0]      a,
	input  logic signed [lsp_pkg::DELTA_W-1:0]  b,
	output logic signed [lsp_pkg::PROD_W-1:0]   p_q
);

	logic signed [lsp_pkg::V_W+lsp_pkg::DELTA_W-1:0] full;

	assign full = a * b;

	always_ff @(posedge clk) begin
		p_q <= full[lsp_pkg::PROD_W-1:0];
	end

endmodule

// ----- hdl/line_sensor_position_unit.sv -----
// top level: frame sequencer, configuration registers and position output
//
// Usage: one sample pair (front_sample, back_sample) is transferred per rising edge
// at which start is high and busy is low. A frame is 2*NUM_SENSORS transfers in
// channel order: the emitter-off readings first, then the emitter-on readings.
// Busy stays low for transfers within a frame.
// The last transfer of a frame starts the position search and busy goes high.
// Per row the unit scans the inner channels one per cycle, reads both neighbors
// of the minimum, then runs two products and a round/saturate step through the
// one shared multiplier. The front row goes first, then the back row.
// When the back row finishes, done is high for exactly one cycle with
// front_position and back_position; the receiver cannot stall, so the result
// is lost if not taken in that cycle. busy is low in that same cycle.
// Configuration writes (cfg_wr, cfg_idx, cfg_data) take effect at the edge and
// are expected only while busy is low.
// Reset clears the frame position, the sequencer and the registers to their
// defaults (pitch 9 mm, gain 84/256 per volt); difference registers hold
// nothing valid until the first half of a frame has loaded them.
module line_sensor_position_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [lsp_pkg::SAMPLE_W-1:0]            front_sample,
	input  logic [lsp_pkg::SAMPLE_W-1:0]            back_sample,
	output logic                                    done,
	output logic signed [lsp_pkg::POS_W-1:0]        front_position,
	output logic signed [lsp_pkg::POS_W-1:0]        back_position,
	input  logic                                    cfg_wr,
	input  logic [lsp_pkg::CFG_IDX_W-1:0]           cfg_idx,
	input  logic [lsp_pkg::CFG_DATA_W-1:0]          cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LEFT,
		S_RIGHT,
		S_SUB,
		S_SCALE,
		S_ROUND
	} state_t;

	state_t                                 state_q;
	logic [lsp_pkg::STEP_W-1:0]             step_q;
	logic                                   row_q;
	lsp_pkg::ch_t                           idx_q;
	lsp_pkg::ch_t                           c_q;
	lsp_pkg::diff_t                         min_q;
	lsp_pkg::diff_t                         left_q;
	logic signed [lsp_pkg::V_W-1:0]         v_q;
	logic [lsp_pkg::PITCH_W-1:0]            pitch_q;
	logic [lsp_pkg::GAIN_W-1:0]             gain_q;
	logic                                   done_q;
	logic signed [lsp_pkg::POS_W-1:0]       front_pos_q;
	logic signed [lsp_pkg::POS_W-1:0]       back_pos_q;

	logic                                   accept;
	lsp_pkg::ch_t                           step_ch;
	lsp_pkg::store_ctl_t                    store_ctl;
	lsp_pkg::diff_t                         rd_front;
	lsp_pkg::diff_t                         rd_back;
	lsp_pkg::diff_t                         rd;
	logic signed [lsp_pkg::DELTA_W-1:0]     delta;
	logic signed [lsp_pkg::V_W-1:0]         center;
	logic signed [lsp_pkg::V_W-1:0]         mul_a;
	logic signed [lsp_pkg::DELTA_W-1:0]     mul_b;
	logic signed [lsp_pkg::PROD_W-1:0]      p_q;
	logic signed [lsp_pkg::PROD_W-1:0]      rounded;
	logic signed [lsp_pkg::Q_W-1:0]         q;
	logic signed [lsp_pkg::POS_W-1:0]       pos;

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign front_position = front_pos_q;
	assign back_position  = back_pos_q;

	always_comb begin
		accept = start && !busy;
		if (step_q >= lsp_pkg::STEP_HALF) begin
			step_ch = lsp_pkg::CH_W'(step_q - lsp_pkg::STEP_HALF);
		end else begin
			step_ch = lsp_pkg::CH_W'(step_q);
		end

		store_ctl.wr  = accept;
		store_ctl.sub = (step_q >= lsp_pkg::STEP_HALF);
		unique case (state_q)
			S_IDLE:  store_ctl.addr = step_ch;
			S_SCAN:  store_ctl.addr = idx_q;
			S_LEFT:  store_ctl.addr = c_q - lsp_pkg::CH_W'(1);
			S_RIGHT: store_ctl.addr = c_q + lsp_pkg::CH_W'(1);
			default: store_ctl.addr = c_q;
		endcase

		rd     = row_q ? rd_back : rd_front;
		delta  = {left_q[lsp_pkg::DIFF_W-1], left_q} - {rd[lsp_pkg::DIFF_W-1], rd};
		center = lsp_pkg::CENTER_BASE - (lsp_pkg::V_W'(c_q) << lsp_pkg::CENTER_SHIFT);

		// gain * delta first, then pitch * (center - gain * delta)
		if (state_q == S_SCALE) begin
			mul_a = v_q;
			mul_b = {{(lsp_pkg::DELTA_W-lsp_pkg::PITCH_W){1'b0}}, pitch_q};
		end else begin
			mul_a = {{(lsp_pkg::V_W-lsp_pkg::GAIN_W){1'b0}}, gain_q};
			mul_b = delta;
		end

		// floor((p + 128) / 256), then clamp to 32 bits
		rounded = p_q + lsp_pkg::PROD_W'(lsp_pkg::ROUND_BIAS);
		q       = rounded[lsp_pkg::PROD_W-1:8];
		if ((&q[lsp_pkg::Q_W-1:lsp_pkg::POS_W-1]) || !(|q[lsp_pkg::Q_W-1:lsp_pkg::POS_W-1])) begin
			pos = q[lsp_pkg::POS_W-1:0];
		end else if (q[lsp_pkg::Q_W-1]) begin
			pos = lsp_pkg::POS_MIN;
		end else begin
			pos = lsp_pkg::POS_MAX;
		end
	end

	lsp_diff_store u_store (
		.clk          (clk),
		.ctl          (store_ctl),
		.front_sample (front_sample),
		.back_sample  (back_sample),
		.rd_front     (rd_front),
		.rd_back      (rd_back)
	);

	lsp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			row_q   <= 1'b0;
			idx_q   <= lsp_pkg::SCAN_FIRST;
			c_q     <= lsp_pkg::SCAN_FIRST;
			done_q  <= 1'b0;
			pitch_q <= lsp_pkg::PITCH_RESET;
			gain_q  <= lsp_pkg::GAIN_RESET;
		end else begin
			done_q <= 1'b0;

			if (cfg_wr) begin
				unique case (cfg_idx)
					lsp_pkg::REG_PITCH: pitch_q <= cfg_data[lsp_pkg::PITCH_W-1:0];
					lsp_pkg::REG_GAIN:  gain_q  <= cfg_data[lsp_pkg::GAIN_W-1:0];
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (step_q == lsp_pkg::STEP_LAST) begin
							step_q  <= '0;
							row_q   <= 1'b0;
							idx_q   <= lsp_pkg::SCAN_FIRST;
							state_q <= S_SCAN;
						end else begin
							step_q <= step_q + lsp_pkg::STEP_W'(1);
						end
					end
				end
				S_SCAN: begin
					// strict compare keeps the lowest channel on ties
					if (idx_q == lsp_pkg::SCAN_FIRST || rd < min_q) begin
						min_q <= rd;
						c_q   <= idx_q;
					end
					if (idx_q == lsp_pkg::SCAN_LAST) begin
						state_q <= S_LEFT;
					end else begin
						idx_q <= idx_q + lsp_pkg::CH_W'(1);
					end
				end
				S_LEFT: begin
					left_q  <= rd;
					state_q <= S_RIGHT;
				end
				S_RIGHT: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					v_q     <= center - p_q[lsp_pkg::V_W-1:0];
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					if (!row_q) begin
						front_pos_q <= pos;
						row_q       <= 1'b1;
						idx_q       <= lsp_pkg::SCAN_FIRST;
						state_q     <= S_SCAN;
					end else begin
						back_pos_q <= pos;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// mid-frame transfers never raise busy
	a_mid_frame_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && step_q != lsp_pkg::STEP_LAST) |=> !busy)
		else $error("busy raised on a mid-frame transfer");

	// the last transfer of a frame starts the search and rewinds the frame position
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && step_q == lsp_pkg::STEP_LAST) |=> (busy && step_q == '0))
		else $error("frame end did not start the search");

	// a result appears only once the unit is ready again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && step_q == '0))
		else $error("result strobe while busy or mid-frame");

	// the result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule
